@@ rtl/ltwp_pkg.sv @@
// package for the logic trace waveform pixel block: codes, level rows and colours
`default_nettype none

package ltwp_pkg;

  localparam int unsigned SampleDepthDef = 256;

  localparam int unsigned ColW   = 9;
  localparam int unsigned RowW   = 8;
  localparam int unsigned PixW   = 16;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned OpW    = 2;

  localparam logic [ColW-1:0] FirstColumnRst = 9'd70;

  typedef enum logic [OpW-1:0] {
    OP_CLEAR   = 2'd0,
    OP_CAPTURE = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  // per channel: select, clock, data out, data in
  localparam logic [RowW-1:0] HiRow [NumCh] = '{8'd55, 8'd100, 8'd145, 8'd190};
  localparam logic [RowW-1:0] LoRow [NumCh] = '{8'd70, 8'd115, 8'd160, 8'd205};

  localparam logic [PixW-1:0] ColBlack = 16'h0000;
  localparam logic [PixW-1:0] ChanColor [NumCh] =
    '{16'h00F8, 16'hE0FF, 16'hE007, 16'hFF07};

endpackage

`default_nettype wire

@@ rtl/ltwp_ram.sv @@
// generic single write port ram with registered read
`default_nettype none

module ltwp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/logic_trace_waveform_pixels_top.sv @@
// top level of the logic trace capture and waveform pixel generator
// a query beat's pixel passes the query stage register, then the output register, before it shows on the master side
// throughput: one beat per cycle of any kind; a ram entry holds the previous sample too,
// so a query needs one ram read. a result beat held by the master side stalls the input
// clear and capture beats give no result beat
// reset: sample count cleared, first column back to 70; the sample ram is not cleared
`default_nettype none

module logic_trace_waveform_pixels_top
  import ltwp_pkg::*;
#(
  parameter int unsigned SAMPLE_DEPTH = SampleDepthDef
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  // configuration write channel: first column
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [ColW-1:0] cfg_data_i,
  // slave side
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  // [0] select, [1] clock, [2] data out, [3] data in, [12:4] column, [20:13] row
  input  wire logic [23:0]     s_axis_tdata,
  // [1:0] opcode
  input  wire logic [OpW-1:0]  s_axis_tuser,
  // master side
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  // [15:0] pixel colour
  output logic [PixW-1:0]      m_axis_tdata
);

  localparam int unsigned AddrW = $clog2(SAMPLE_DEPTH);
  localparam int unsigned CntW  = $clog2(SAMPLE_DEPTH + 1);
  localparam int unsigned EntW  = 2 * NumCh;

  logic [ColW-1:0]  first_col_q;
  logic [CntW-1:0]  count_q, count_d;
  logic [NumCh-1:0] last_q;

  logic             q_vld_q, hit_q;
  logic [RowW-1:0]  row_q;
  logic             out_vld_q;
  logic [PixW-1:0]  out_pix_q, pix_d;

  logic             adv, s_fire;
  op_e              op;
  logic [NumCh-1:0] smp;
  logic [ColW-1:0]  col, s_idx;
  logic [RowW-1:0]  row;
  logic             cap_we, rd_en, hit_d;
  logic [EntW-1:0]  wr_ent, rd_ent;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_col_q <= FirstColumnRst;
    end else if (cfg_valid_i) begin
      first_col_q <= cfg_data_i;
    end
  end

  // the whole pipe moves unless a result beat is waiting
  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_fire        = s_axis_tvalid && adv;

  assign op  = op_e'(s_axis_tuser);
  assign smp = s_axis_tdata[NumCh-1:0];
  assign col = s_axis_tdata[NumCh +: ColW];
  assign row = s_axis_tdata[NumCh+ColW +: RowW];

  // each entry keeps the previous sample beside the current one
  assign wr_ent = (count_q == '0) ? {smp, smp} : {last_q, smp};
  assign cap_we = s_fire && (op == OP_CAPTURE) && (count_q < CntW'(SAMPLE_DEPTH));

  assign s_idx  = col - first_col_q;
  assign hit_d  = (col >= first_col_q) && (s_idx < ColW'(count_q));
  assign rd_en  = s_fire && (op == OP_QUERY);

  always_comb begin
    count_d = count_q;
    if (s_fire) begin
      case (op)
        OP_CLEAR:   count_d = '0;
        OP_CAPTURE: if (cap_we) count_d = count_q + 1'b1;
        default:    count_d = count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_we) begin
      last_q <= smp;
    end
  end

  ltwp_ram #(
    .Width (EntW),
    .Depth (SAMPLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cap_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (wr_ent),
    .re_i    (rd_en),
    .raddr_i (s_idx[AddrW-1:0]),
    .rdata_o (rd_ent)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_vld_q <= 1'b0;
    end else if (adv) begin
      q_vld_q <= rd_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      hit_q <= hit_d;
      row_q <= row;
    end
  end

  // later channels win where spans meet
  always_comb begin
    logic [RowW-1:0] ra, rb;
    pix_d = ColBlack;
    ra    = '0;
    rb    = '0;
    for (int ch = 0; ch < NumCh; ch++) begin
      ra = rd_ent[ch]         ? HiRow[ch] : LoRow[ch];
      rb = rd_ent[NumCh + ch] ? HiRow[ch] : LoRow[ch];
      if ((row_q == ra) || (row_q == rb) ||
          ((ra != rb) && (row_q >= HiRow[ch]) && (row_q <= LoRow[ch]))) begin
        pix_d = ChanColor[ch];
      end
    end
    if (!hit_q) begin
      pix_d = ColBlack;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= q_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && q_vld_q) begin
      out_pix_q <= pix_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_pix_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(SAMPLE_DEPTH))
    else $error("sample count past depth");

  a_no_result_for_other: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && (op != OP_QUERY)) |=> !q_vld_q)
    else $error("result staged for a non-query beat");

  a_empty_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && (count_q == '0)) |=> !hit_q)
    else $error("hit on an empty trace");

endmodule

`default_nettype wire
